// ----- src/ded_pkg.sv -----
package ded_pkg;

   localparam int DEF_NEIGHBOURS = 8;
   localparam int DEF_DEPTH_BITS = 24;
   localparam int MAX_NEIGHBOURS = 8;
   localparam int EYE_W          = 32;
   localparam int CNT_W          = 4;
   localparam int CSR_W          = 32;
   localparam int CSR_IDX_W      = 2;
   localparam int DIV_STEPS      = EYE_W;

   typedef logic [EYE_W-1:0] eye_type;
   typedef logic [CNT_W-1:0] cnt_type;

   localparam eye_type EYE_FAR = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PROJ_OFFSET    = 2'd0,
      CSR_PROJ_SCALE     = 2'd1,
      CSR_PROJ_NUMERATOR = 2'd2
   } csr_idx_type;

endpackage

// ----- src/ded_lane.sv -----
module ded_lane import ded_pkg::*; #(
   parameter int DEPTH_BITS = DEF_DEPTH_BITS
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic [DEPTH_BITS-1:0] depth,
   input  logic [CSR_W-1:0]      p10,
   input  logic [CSR_W-1:0]      p11,
   input  logic [CSR_W-1:0]      p14,
   output eye_type               eye
);

   localparam int E     = (DEPTH_BITS > 30) ? 30 : DEPTH_BITS;
   localparam int DEN_W = E + 35;
   localparam int PRD_W = E + 34;
   localparam longint unsigned FAR_MIN =
      (64'd999999 * (64'd1 << DEPTH_BITS) + 64'd999999) / 64'd1000000;
   localparam longint unsigned NZ_MAX = ((64'd1 << (E + 16)) - 64'd1) / 64'd1000000;
   localparam logic [E+1:0] ONE_E = (E+2)'(1) << E;
   localparam logic [DEN_W-1:0] NZ_LIMIT = DEN_W'(NZ_MAX);

   // projection stage
   logic [E-1:0]             dr;
   logic signed [E+1:0]      ndc;
   logic signed [PRD_W-1:0]  prod;
   logic [DEN_W-1:0]         p10_ext;
   logic signed [DEN_W-1:0]  den_in;
   logic                     far_depth_in;
   logic signed [DEN_W-1:0]  den_ff;
   logic                     far_depth_ff;

   always_comb begin
      dr           = depth[DEPTH_BITS-1 -: E];
      ndc          = $signed({1'b0, dr, 1'b0} - ONE_E);
      prod         = ndc * $signed(p11);
      p10_ext      = {{(DEN_W-CSR_W){p10[CSR_W-1]}}, p10} << E;
      den_in       = $signed({prod[PRD_W-1], prod}) - $signed(p10_ext);
      far_depth_in = {1'b0, depth} >= FAR_MIN[DEPTH_BITS:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff       <= den_in;
         far_depth_ff <= far_depth_in;
      end
   end

   // magnitude and range checks
   logic [DEN_W-1:0] mag_in;
   logic [CSR_W-1:0] num_mag;
   logic [DEN_W-1:0] rem0_in;
   logic             far0_in;

   logic [DEN_W-1:0] rem_ff [DIV_STEPS+1];
   logic [DEN_W-1:0] mag_ff [DIV_STEPS+1];
   logic             far_ff [DIV_STEPS+1];
   eye_type          quo_ff [DIV_STEPS+1];

   always_comb begin
      mag_in  = den_ff[DEN_W-1] ? DEN_W'(-den_ff) : DEN_W'(den_ff);
      num_mag = p14[CSR_W-1] ? CSR_W'(-p14) : p14;
      rem0_in = {{(DEN_W-CSR_W){1'b0}}, num_mag} << (E - 16);
      far0_in = far_depth_ff || (mag_in <= NZ_LIMIT) || (rem0_in >= mag_in);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= rem0_in;
         mag_ff[0] <= mag_in;
         far_ff[0] <= far0_in;
         quo_ff[0] <= '0;
      end
   end

   // restoring divider, one quotient bit per stage
   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      logic [DEN_W:0]   rem_sh;
      logic             ge;
      logic [DEN_W-1:0] rem_in;

      always_comb begin
         rem_sh = {rem_ff[i], 1'b0};
         ge     = rem_sh >= {1'b0, mag_ff[i]};
         rem_in = ge ? DEN_W'(rem_sh - {1'b0, mag_ff[i]}) : DEN_W'(rem_sh);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i+1] <= rem_in;
            mag_ff[i+1] <= mag_ff[i];
            far_ff[i+1] <= far_ff[i];
            quo_ff[i+1] <= {quo_ff[i][EYE_W-2:0], ge};
         end
      end
   end

   assign eye = far_ff[DIV_STEPS] ? EYE_FAR : quo_ff[DIV_STEPS];

endmodule

// ----- src/ded_merge.sv -----
module ded_merge import ded_pkg::*; #(
   parameter int NEIGHBOURS = DEF_NEIGHBOURS
) (
   input  logic    clock,
   input  logic    en,
   input  eye_type center_eye,
   input  eye_type nb_eye [NEIGHBOURS],
   input  cnt_type count,
   output logic    is_edge,
   output eye_type center_out,
   output eye_type farthest_out
);

   eye_type  far_in;
   eye_type  center_ff;
   eye_type  far_ff;
   logic     any_ff;

   always_comb begin
      far_in = center_eye;
      for (int k = 0; k < NEIGHBOURS; k++) begin
         if ((CNT_W'(k) < count) && (nb_eye[k] > far_in)) begin
            far_in = nb_eye[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         center_ff <= center_eye;
         far_ff    <= far_in;
         any_ff    <= count != '0;
      end
   end

   // threshold test
   eye_type        diff;
   logic [EYE_W+4:0] diff25;
   logic [EYE_W+6:0] diff80;
   logic           edge_in;

   always_comb begin
      diff    = far_ff - center_ff;
      diff25  = {diff, 4'b0} + {2'b0, diff, 3'b0} + {5'b0, diff};
      diff80  = {diff, 6'b0} + {2'b0, diff, 4'b0};
      edge_in = (center_ff != EYE_FAR) && any_ff &&
                ((far_ff == EYE_FAR) ||
                 ((diff25 > (EYE_W+5)'(65536)) && (diff80 > {7'b0, center_ff})));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         is_edge      <= edge_in;
         center_out   <= center_ff;
         farthest_out <= far_ff;
      end
   end

endmodule

// ----- src/depth_edge_detector_top.sv -----
// throughput: one pixel per cycle while rsp is not stalled, nine eye-depth lanes with a 32-stage divider each
// a stalled rsp beat holds the whole pipeline
// synchronous reset clears the pipeline valid bits and the projection terms
module depth_edge_detector_top import ded_pkg::*; #(
   parameter int NEIGHBOURS = DEF_NEIGHBOURS,
   parameter int DEPTH_BITS = DEF_DEPTH_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [DEPTH_BITS-1:0] req_center_depth,
   input  logic [DEPTH_BITS-1:0] req_neighbour_depth_0,
   input  logic [DEPTH_BITS-1:0] req_neighbour_depth_1,
   input  logic [DEPTH_BITS-1:0] req_neighbour_depth_2,
   input  logic [DEPTH_BITS-1:0] req_neighbour_depth_3,
   input  logic [DEPTH_BITS-1:0] req_neighbour_depth_4,
   input  logic [DEPTH_BITS-1:0] req_neighbour_depth_5,
   input  logic [DEPTH_BITS-1:0] req_neighbour_depth_6,
   input  logic [DEPTH_BITS-1:0] req_neighbour_depth_7,
   input  cnt_type               req_valid_neighbours,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_is_edge,
   output eye_type               rsp_center_eye_depth,
   output eye_type               rsp_farthest_eye_depth,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]      csr_write_data
);

   localparam int LANE_LAT = DIV_STEPS + 2;
   localparam int TOTAL    = LANE_LAT + 3;

   logic [CSR_W-1:0] p10_ff, p11_ff, p14_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p10_ff <= '0;
         p11_ff <= '0;
         p14_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_idx_type'(csr_index))
            CSR_PROJ_OFFSET:    p10_ff <= csr_write_data;
            CSR_PROJ_SCALE:     p11_ff <= csr_write_data;
            CSR_PROJ_NUMERATOR: p14_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   logic en;
   logic vld_ff [TOTAL];

   assign en        = !vld_ff[TOTAL-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[TOTAL-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TOTAL; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < TOTAL; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // input register
   logic [DEPTH_BITS-1:0] nb_depth [MAX_NEIGHBOURS];
   logic [DEPTH_BITS-1:0] center_ff;
   logic [DEPTH_BITS-1:0] nb_ff [NEIGHBOURS];
   cnt_type               cnt_in;
   cnt_type               cnt_ff [LANE_LAT+1];

   always_comb begin
      nb_depth[0] = req_neighbour_depth_0;
      nb_depth[1] = req_neighbour_depth_1;
      nb_depth[2] = req_neighbour_depth_2;
      nb_depth[3] = req_neighbour_depth_3;
      nb_depth[4] = req_neighbour_depth_4;
      nb_depth[5] = req_neighbour_depth_5;
      nb_depth[6] = req_neighbour_depth_6;
      nb_depth[7] = req_neighbour_depth_7;
      cnt_in = (req_valid_neighbours > CNT_W'(NEIGHBOURS)) ?
               CNT_W'(NEIGHBOURS) : req_valid_neighbours;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         center_ff <= req_center_depth;
         for (int k = 0; k < NEIGHBOURS; k++) nb_ff[k] <= nb_depth[k];
         cnt_ff[0] <= cnt_in;
         for (int i = 1; i <= LANE_LAT; i++) cnt_ff[i] <= cnt_ff[i-1];
      end
   end

   // lanes
   eye_type center_eye;
   eye_type nb_eye [NEIGHBOURS];

   ded_lane #(.DEPTH_BITS(DEPTH_BITS)) u_center_lane (
      .clock (clock),
      .en    (en),
      .depth (center_ff),
      .p10   (p10_ff),
      .p11   (p11_ff),
      .p14   (p14_ff),
      .eye   (center_eye)
   );

   for (genvar k = 0; k < NEIGHBOURS; k++) begin : g_lane
      ded_lane #(.DEPTH_BITS(DEPTH_BITS)) u_lane (
         .clock (clock),
         .en    (en),
         .depth (nb_ff[k]),
         .p10   (p10_ff),
         .p11   (p11_ff),
         .p14   (p14_ff),
         .eye   (nb_eye[k])
      );
   end

   ded_merge #(.NEIGHBOURS(NEIGHBOURS)) u_merge (
      .clock        (clock),
      .en           (en),
      .center_eye   (center_eye),
      .nb_eye       (nb_eye),
      .count        (cnt_ff[LANE_LAT]),
      .is_edge      (rsp_is_edge),
      .center_out   (rsp_center_eye_depth),
      .farthest_out (rsp_farthest_eye_depth)
   );

endmodule
